@@ rtl/core/hgms_pkg.sv @@
// hunt group member selector package: widths, register indexes and the
// first-free pick function shared by the selector RTL
// no dependencies
package hgms_pkg;

  // member mask and index widths
  localparam int unsigned FreeW    = 16;
  localparam int unsigned MemberW  = 4;
  localparam int unsigned CountW   = 5;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 5;

  // largest group the selector hunts over
  localparam logic [CountW-1:0] MaxMembers = CountW'(16);

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgHuntMode    = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMemberCount = 1'b1;

  // hunt modes
  localparam logic HuntSequential = 1'b0;
  localparam logic HuntCyclic     = 1'b1;

  // result of a priority pick over a member mask
  typedef struct packed {
    logic               hit;
    logic [MemberW-1:0] idx;
  } pick_t;

  // lowest set bit of a member mask
  function automatic pick_t first_set(logic [FreeW-1:0] vec);
    pick_t res;
    res = '0;
    for (int i = FreeW - 1; i >= 0; i--) begin
      if (vec[i]) begin
        res.hit = 1'b1;
        res.idx = MemberW'(i);
      end
    end
    return res;
  endfunction

endpackage

@@ rtl/core/hunt_group_member_selector_unit.sv @@
// hunt group member selector top level: input register, one-pass
// rotate-and-pick search, result register and last-grant state
// depends on hgms_pkg
//
// usage
// - request channel: in_valid_i / in_stall_o with member_free_i, resume_valid_i,
//   resume_index_i, stop_valid_i and stop_index_i; a transfer happens on a
//   rising edge with valid high and stall low
// - result channel: out_valid_o / out_stall_i with found_o and member_index_o,
//   one result per request, in request order
// - config channel: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
//   index 0 is the hunt mode, index 1 the member count; ready is always high,
//   writes are expected only while no request is in flight
// - a transferred request is held in the input register, searched by the
//   combinational search and its result registered in the result register,
//   which then raises result valid; throughput is one request per cycle while
//   the receiver does not stall
// - the last granted member is updated in the same cycle a result is
//   registered, so the next request sees it without a bubble
// - when the receiver stalls, the result register holds and the input
//   register still takes one more request; stall reaches the sender only
//   when both are full
// - reset clears the config registers, the last grant and both valid flags
module hunt_group_member_selector_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // config write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [hgms_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hgms_pkg::CfgDataW-1:0] cfg_data_i,
  // request channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [hgms_pkg::FreeW-1:0]    member_free_i,
  input  logic                         resume_valid_i,
  input  logic [hgms_pkg::MemberW-1:0]  resume_index_i,
  input  logic                         stop_valid_i,
  input  logic [hgms_pkg::MemberW-1:0]  stop_index_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         found_o,
  output logic [hgms_pkg::MemberW-1:0]  member_index_o
);
  import hgms_pkg::*;

  // config registers
  logic              hunt_mode_q;
  logic [CountW-1:0] member_count_q;

  // input register
  logic               req_valid_q;
  logic [FreeW-1:0]   free_q;
  logic               res_valid_q;
  logic [MemberW-1:0] res_index_q;
  logic               stp_valid_q;
  logic [MemberW-1:0] stp_index_q;

  // result register
  logic               out_valid_q;
  logic               found_q;
  logic [MemberW-1:0] member_index_q;

  // hunt state
  logic               last_q;
  logic [MemberW-1:0] last_granted_q;

  // search signals
  logic [CountW-1:0]  n_eff;
  logic [CountW-1:0]  res_next;
  logic [CountW-1:0]  last_next;
  logic [MemberW-1:0] start;
  logic               stop_in;
  logic [FreeW-1:0]   cand;
  logic [FreeW-1:0]   upper;
  pick_t              pick_hi;
  pick_t              pick_lo;
  pick_t              pick;
  logic               advance;

  // config writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hunt_mode_q    <= HuntSequential;
      member_count_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgHuntMode:    hunt_mode_q    <= cfg_data_i[0];
        CfgMemberCount: member_count_q <= cfg_data_i;
        default:        ;
      endcase
    end
  end

  // handshake: the input register moves on when the result register is free
  assign advance     = req_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = req_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      free_q      <= member_free_i;
      res_valid_q <= resume_valid_i;
      res_index_q <= resume_index_i;
      stp_valid_q <= stop_valid_i;
      stp_index_q <= stop_index_i;
    end
  end

  // effective group size and search start
  assign n_eff     = (member_count_q > MaxMembers) ? MaxMembers : member_count_q;
  assign res_next  = {1'b0, res_index_q} + CountW'(1);
  assign last_next = {1'b0, last_granted_q} + CountW'(1);

  always_comb begin
    start = '0;
    if (res_valid_q) begin
      if ({1'b0, res_index_q} < n_eff) begin
        start = (res_next == n_eff) ? '0 : res_next[MemberW-1:0];
      end
    end else if (hunt_mode_q == HuntCyclic && last_q &&
                 {1'b0, last_granted_q} < n_eff) begin
      start = (last_next == n_eff) ? '0 : last_next[MemberW-1:0];
    end
  end

  // stop member only counts when it lies inside the group
  assign stop_in = stp_valid_q && ({1'b0, stp_index_q} < n_eff);

  // candidate mask: free members the search reaches before the stop member
  always_comb begin
    for (int i = 0; i < FreeW; i++) begin
      logic in_grp;
      logic hi;
      logic below_stop;
      logic allowed;
      in_grp     = CountW'(i) < n_eff;
      hi         = MemberW'(i) >= start;
      below_stop = MemberW'(i) < stp_index_q;
      if (!stop_in) begin
        allowed = 1'b1;
      end else if (stp_index_q >= start) begin
        allowed = hi && below_stop;
      end else begin
        allowed = hi || below_stop;
      end
      upper[i] = hi;
      cand[i]  = free_q[i] && in_grp && allowed;
    end
  end

  // wrapped search: members from the start upward first, then the low ones
  assign pick_hi = first_set(cand & upper);
  assign pick_lo = first_set(cand & ~upper);
  assign pick    = pick_hi.hit ? pick_hi : pick_lo;

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      found_q        <= pick.hit;
      member_index_q <= pick.hit ? pick.idx : '0;
    end
  end

  // last grant update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q         <= 1'b0;
      last_granted_q <= '0;
    end else if (advance && pick.hit) begin
      last_q         <= 1'b1;
      last_granted_q <= pick.idx;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign member_index_o = member_index_q;

  // checks
  a_no_grant_zero_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> member_index_o == '0)
    else $error("result without grant carries a nonzero member index");

  a_grant_in_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> {1'b0, member_index_o} < n_eff)
    else $error("granted member lies outside the group");

  a_grant_sets_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && pick.hit |=> last_q && last_granted_q == member_index_o)
    else $error("last grant state does not follow the registered grant");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> req_valid_q && out_valid_q && out_stall_i)
    else $error("request stalled while the pipeline has room");

  a_grant_is_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && pick.hit |-> free_q[pick.idx])
    else $error("granted member has no free channel");

endmodule
